### rtl/l2s_pkg.sv
// Shared types and the threshold table for the linear to sRGB 8-bit encoder.
// The table is built at elaboration by exact integer arithmetic; no dependencies.
package l2s_pkg;

	localparam int unsigned CodeW    = 8;
	localparam int unsigned MagW     = 31;
	localparam int unsigned StageCnt = CodeW;
	localparam int unsigned BigW     = 640;

	localparam logic [MagW-1:0] OneMag  = 31'h3F80_0000;
	localparam logic [MagW-1:0] NanMin  = 31'h7F80_0001;
	localparam logic [MagW-1:0] MagZero = '0;
	localparam logic [MagW-1:0] MagFull = '1;

	localparam logic [BigW-1:0] LinScale   = BigW'(10000000);
	localparam logic [BigW-1:0] LinKnee    = BigW'(31308);
	localparam logic [BigW-1:0] LinSlope   = BigW'(1292);
	localparam logic [BigW-1:0] OutScale   = BigW'(2559999);
	localparam logic [BigW-1:0] LinStep    = BigW'(1000000);
	localparam logic [BigW-1:0] GammaStep  = BigW'(10000000);
	localparam logic [BigW-1:0] GammaOfs   = BigW'(140799945);
	localparam logic [BigW-1:0] GammaDen   = BigW'(64'd2700798945);

	typedef struct packed {
		logic [MagW-1:0]  mag;
		logic [CodeW-1:0] code;
	} pix_t;

	typedef logic [(1 << CodeW)-1:0][MagW-1:0] thresh_rom_t;

	// true when the positive value with magnitude bits mag maps to a code of k or more
	function automatic logic reaches(input logic [MagW-1:0] mag, input int unsigned k);
		logic [7:0]      e;
		logic [23:0]     m;
		int unsigned     s;
		logic [BigW-1:0] l;
		logic [BigW-1:0] r;
		logic [BigW-1:0] num;
		logic            res;
		e = mag[30:23];
		if (e == 8'd0) begin
			m = {1'b0, mag[22:0]};
			s = 149;
		end else begin
			m = {1'b1, mag[22:0]};
			s = 150 - int'(e);
		end
		l = BigW'(m) * LinScale;
		r = LinKnee << s;
		if (l <= r) begin
			l = BigW'(m) * LinSlope * OutScale;
			r = (BigW'(k) * LinStep) << s;
			res = (l >= r);
		end else begin
			num = BigW'(k) * GammaStep + GammaOfs;
			l = BigW'(m);
			for (int i = 0; i < 4; i++)
				l = l * BigW'(m);
			for (int i = 0; i < 12; i++)
				l = l * GammaDen;
			r = num;
			for (int i = 0; i < 11; i++)
				r = r * num;
			r = r << (5 * s);
			res = (l >= r);
		end
		return res;
	endfunction

	// smallest magnitude that reaches each code; entry zero is unused
	function automatic thresh_rom_t build_rom();
		thresh_rom_t     rom;
		logic [MagW-1:0] lo;
		logic [MagW-1:0] hi;
		logic [MagW-1:0] mid;
		rom = '0;
		for (int k = 1; k < (1 << CodeW); k++) begin
			lo = 31'd1;
			hi = OneMag - 31'd1;
			for (int i = 0; i < MagW; i++) begin
				if (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if (reaches(mid, k))
						hi = mid;
					else
						lo = mid + 31'd1;
				end
			end
			rom[CodeW'(k)] = lo;
		end
		return rom;
	endfunction

	localparam thresh_rom_t ThreshRom = build_rom();

endpackage

### rtl/l2s_search.sv
// Eight-stage binary search of the threshold table, one code bit per stage.
// Depends on l2s_pkg.
module l2s_search import l2s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             vld_in,
	input  pix_t             pix_in,
	output logic             vld_out,
	output logic [CodeW-1:0] code_out
);

	// index is the stage number: stage 1 is pix_in, stage 9 the last register
	logic vld_s [2:StageCnt+1];
	pix_t pix_s [2:StageCnt+1];

	for (genvar i = 0; i < StageCnt; i++) begin : g_stage
		localparam logic [CodeW-1:0] Bit = CodeW'(1) << (CodeW - 1 - i);
		logic             vld_cur;
		pix_t             pix_cur;
		logic [CodeW-1:0] cand;
		pix_t             pix_nxt;

		if (i == 0) begin : g_first
			assign vld_cur = vld_in;
			assign pix_cur = pix_in;
		end else begin : g_rest
			assign vld_cur = vld_s[i+1];
			assign pix_cur = pix_s[i+1];
		end

		always_comb begin
			cand         = pix_cur.code | Bit;
			pix_nxt.mag  = pix_cur.mag;
			pix_nxt.code = (pix_cur.mag >= ThreshRom[cand]) ? cand : pix_cur.code;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+2] <= 1'b0;
			end else if (advance) begin
				vld_s[i+2] <= vld_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				pix_s[i+2] <= pix_nxt;
			end
		end
	end

	assign vld_out  = vld_s[StageCnt+1];
	assign code_out = pix_s[StageCnt+1].code;

endmodule

### rtl/linear_to_srgb8_encode_top.sv
// Linear-light float to 8-bit sRGB encoder, top level.
// Throughput: one request per cycle while a valid result is not stalled; one input
// register and eight search stages move together, each stage one table lookup and
// one 31-bit compare.
// Reset clears every stage valid bit; data registers are not reset.
// Depends on l2s_pkg and l2s_search.
module linear_to_srgb8_encode_top import l2s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             linear_valid,
	output logic             linear_stall,
	input  logic [31:0]      linear_value,
	output logic             srgb_valid,
	input  logic             srgb_stall,
	output logic [CodeW-1:0] srgb_code
);

	logic            advance;
	logic            vld_s1;
	pix_t            pix_s1;
	logic [MagW-1:0] mag_in;

	assign advance      = !(srgb_valid && srgb_stall);
	assign linear_stall = !advance;

	// fold sign, NaN and overrange into magnitudes that search to 0 or 255
	always_comb begin
		priority if (linear_value[31])
			mag_in = MagZero;
		else if (linear_value[30:0] >= NanMin)
			mag_in = MagZero;
		else if (linear_value[30:0] >= OneMag)
			mag_in = MagFull;
		else
			mag_in = linear_value[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= linear_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1.mag  <= mag_in;
			pix_s1.code <= '0;
		end
	end

	l2s_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.vld_in   (vld_s1),
		.pix_in   (pix_s1),
		.vld_out  (srgb_valid),
		.code_out (srgb_code)
	);

endmodule

### rtl/l2s_checker.sv
// Port-level checks for the encoder top level, bound to every instance.
// Depends on l2s_pkg.
module l2s_checker import l2s_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             linear_valid,
	input logic             linear_stall,
	input logic             srgb_valid,
	input logic             srgb_stall,
	input logic [CodeW-1:0] srgb_code
);

	logic take;
	logic flow;

	assign take = linear_valid && !linear_stall && arst_n;
	assign flow = !srgb_stall && arst_n;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		srgb_valid && srgb_stall |=> srgb_valid && $stable(srgb_code))
		else $error("result dropped or changed while stalled");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		linear_stall == (srgb_valid && srgb_stall))
		else $error("input stall does not follow a blocked output");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(take, 9) && $past(flow, 1) && $past(flow, 2) && $past(flow, 3)
		&& $past(flow, 4) && $past(flow, 5) && $past(flow, 6) && $past(flow, 7)
		&& $past(flow, 8) |-> srgb_valid)
		else $error("request lost in the pipeline");

endmodule

bind linear_to_srgb8_encode_top l2s_checker u_l2s_checker (.*);
